/* src/psb_pkg.sv */
// Shared types and constants for the pixel sum binning block.
`default_nettype none
package psb_pkg;

    // Widths of the configuration registers and of the request fields.
    localparam int unsigned CFG_DATA_W  = 12;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned SHIFT_W     = 3;
    localparam int unsigned PIXEL_W     = 8;
    localparam int unsigned SUM_W       = 16;
    localparam int unsigned ACC_W       = 18;
    localparam int unsigned BIN_IDX_W   = 10;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BIN_SHIFT    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic [SHIFT_W-1:0]    BIN_SHIFT_RST    = 3'd1;

    // One finished bin as it travels to the output queue.
    typedef struct packed {
        logic [SUM_W-1:0]     sum;
        logic [BIN_IDX_W-1:0] row;
        logic [BIN_IDX_W-1:0] col;
        logic                 last;
    } psb_result_t;

    // Occupancy of the output queue as seen by the top level.
    typedef struct packed {
        logic [1:0] count;
    } psb_queue_status_t;

endpackage
`default_nettype wire

/* src/psb_out_queue.sv */
// Two-entry output queue that decouples the accumulate stage from the output stall.
`default_nettype none
module psb_out_queue
    import psb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire psb_result_t       push_data,
    input  wire logic              pop_stall,
    output logic                   pop_valid,
    output psb_result_t            pop_data,
    output psb_queue_status_t      status
);

    psb_result_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;

    assign pop_valid    = (count_reg != 2'd0);
    assign pop_data     = entry_reg[rd_ptr_reg];
    assign pop          = pop_valid && !pop_stall;
    assign status.count = count_reg;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

/* src/pixel_sum_binning_top.sv */
// Top level of the pixel sum binning block: line store, accumulate stage and output queue.
// A bin's result goes through the accumulate stage register and a queue entry to the output.
// Throughput: one pixel per cycle unless stalled; line store reads on accept, writes in the
// next cycle, with the just-computed sum forwarded when consecutive pixels share a bin column.
// Input stalls while the queue entries plus the result in flight reach two, which only
// happens when the output is stalled.
// Reset: configuration returns to 640 x 480 with shift 1, positions go to zero, the
// pipeline and queue empty; the line store is not cleared (each entry is written first).
`default_nettype none
module pixel_sum_binning_top
    import psb_pkg::*;
#(
    parameter int unsigned MAX_WIDTH     = 2048,
    parameter int unsigned MAX_HEIGHT    = 2048,
    parameter int unsigned MAX_BIN_SHIFT = 5
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [PIXEL_W-1:0]     pixel,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [SUM_W-1:0]            bin_sum,
    output logic [BIN_IDX_W-1:0]        bin_row,
    output logic [BIN_IDX_W-1:0]        bin_col,
    output logic                        frame_last
);

    localparam int unsigned CW     = $clog2(MAX_WIDTH);
    localparam int unsigned RW     = $clog2(MAX_HEIGHT);
    localparam int unsigned DEPTH  = MAX_WIDTH / 2;
    localparam int unsigned IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SW     = $clog2(MAX_BIN_SHIFT + 1);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] frame_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;
    logic [SHIFT_W-1:0]    bin_shift_reg;
    logic                  cfg_hit;

    // Raster position of the next pixel.
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    // Effective geometry.
    logic [31:0]   w_eff;
    logic [31:0]   h_eff;
    logic [SW-1:0] s_eff;
    logic [31:0]   edge_mask;
    logic [31:0]   col32;
    logic [31:0]   row32;
    logic          in_region;
    logic          first_pix;
    logic          last_pix;
    logic          last_bin;
    logic [IW-1:0] bc_now;
    logic          accept;

    // Accumulate stage.
    logic                 s1_valid_reg;
    logic                 s1_first_reg;
    logic                 s1_res_reg;
    logic                 s1_last_reg;
    logic [IW-1:0]        s1_bc_reg;
    logic [BIN_IDX_W-1:0] s1_br_reg;
    logic [PIXEL_W-1:0]   s1_pixel_reg;
    logic                 fwd_reg;
    logic [ACC_W-1:0]     fwd_data_reg;
    logic [ACC_W-1:0]     rd_data_reg;
    logic [ACC_W-1:0]     s1_operand;
    logic [ACC_W-1:0]     s1_sum;

    // Line store of partial sums, one entry per bin column.
    logic [ACC_W-1:0] line_mem [DEPTH];

    // Output queue.
    psb_result_t       q_push_data;
    psb_result_t       q_pop_data;
    psb_queue_status_t q_status;
    logic [2:0]        q_load;

    assign accept  = in_valid && !in_stall;
    assign cfg_hit = cfg_we && (cfg_index == REG_FRAME_WIDTH ||
                                cfg_index == REG_FRAME_HEIGHT ||
                                cfg_index == REG_BIN_SHIFT);

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            bin_shift_reg    <= BIN_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_BIN_SHIFT:    bin_shift_reg    <= cfg_data[SHIFT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp the geometry into its meaningful range.
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = 32'd1;
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = 32'(MAX_WIDTH);
        end
        else
        begin
            w_eff = 32'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            h_eff = 32'd1;
        end
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = 32'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = 32'(frame_height_reg);
        end

        if (bin_shift_reg == '0)
        begin
            s_eff = SW'(1);
        end
        else if (32'(bin_shift_reg) > 32'(MAX_BIN_SHIFT))
        begin
            s_eff = SW'(MAX_BIN_SHIFT);
        end
        else
        begin
            s_eff = SW'(bin_shift_reg);
        end
    end

    // Position within the bin grid for the current pixel.
    always_comb
    begin
        edge_mask = (32'd1 << s_eff) - 32'd1;
        col32     = 32'(col_reg);
        row32     = 32'(row_reg);
        in_region = (col32 < (w_eff & ~edge_mask)) && (row32 < (h_eff & ~edge_mask));
        first_pix = ((col32 & edge_mask) == 32'd0) && ((row32 & edge_mask) == 32'd0);
        last_pix  = ((col32 & edge_mask) == edge_mask) && ((row32 & edge_mask) == edge_mask);
        last_bin  = ((col32 + 32'd1) == (w_eff & ~edge_mask)) &&
                    ((row32 + 32'd1) == (h_eff & ~edge_mask));
        bc_now    = IW'(col32 >> s_eff);
    end

    // Raster position advance, wrapping at the row and frame ends, reset to zero by a configuration write.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if ((col32 + 32'd1) >= w_eff)
            begin
                col_next = '0;
                if ((row32 + 32'd1) >= h_eff)
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Accumulate stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_res_reg   <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && in_region;
            s1_res_reg   <= accept && in_region && last_pix;
            fwd_reg      <= accept && s1_valid_reg && (s1_bc_reg == bc_now);
        end
    end

    // Accumulate stage payload, including the forwarded sum.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_first_reg <= first_pix;
            s1_last_reg  <= last_bin;
            s1_bc_reg    <= bc_now;
            s1_br_reg    <= BIN_IDX_W'(row32 >> s_eff);
            s1_pixel_reg <= pixel;
            fwd_data_reg <= s1_sum;
        end
    end

    // Line store read on accept.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= line_mem[bc_now];
        end
    end

    // Line store write back from the accumulate stage.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            line_mem[s1_bc_reg] <= s1_sum;
        end
    end

    // First pixel of a bin overwrites; others add to the stored partial sum.
    always_comb
    begin
        s1_operand = fwd_reg ? fwd_data_reg : rd_data_reg;
        if (s1_first_reg)
        begin
            s1_sum = ACC_W'(s1_pixel_reg);
        end
        else
        begin
            s1_sum = s1_operand + ACC_W'(s1_pixel_reg);
        end
    end

    // Finished bin toward the output queue.
    always_comb
    begin
        q_push_data.sum  = s1_sum[SUM_W-1:0];
        q_push_data.row  = s1_br_reg;
        q_push_data.col  = BIN_IDX_W'(s1_bc_reg);
        q_push_data.last = s1_last_reg;
    end

    psb_out_queue u_out_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_res_reg),
        .push_data (q_push_data),
        .pop_stall (out_stall),
        .pop_valid (out_valid),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    // Hold requests while the queue and the result in flight could overflow.
    assign q_load   = {1'b0, q_status.count} + {2'b00, s1_res_reg};
    assign in_stall = (q_load >= 3'd2);

    assign bin_sum    = q_pop_data.sum;
    assign bin_row    = q_pop_data.row;
    assign bin_col    = q_pop_data.col;
    assign frame_last = q_pop_data.last;

    // The queue never holds more than its two entries together with the result in flight.
    assert property (@(posedge clk) disable iff (!rst_n) q_load <= 3'd2)
        else $error("output queue overflow");

    // A result is only pushed for a pixel that passed the accumulate stage.
    assert property (@(posedge clk) disable iff (!rst_n) s1_res_reg |-> s1_valid_reg)
        else $error("result without an accumulate stage item");

    // Forwarding is only selected when the previous stage item was live.
    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> $past(s1_valid_reg))
        else $error("forward selected without a prior write");

endmodule
`default_nettype wire

/* sim/tb_pixel_sum_binning_top.sv */
// Self-checking testbench for the pixel sum binning top level with its own bin predictor.
`default_nettype none
module tb_pixel_sum_binning_top;
    import psb_pkg::*;

    localparam int unsigned MAX_W        = 2048;
    localparam int unsigned MAX_H        = 2048;
    localparam int unsigned MAX_SHIFT    = 5;
    localparam int unsigned STORE_DEPTH  = MAX_W / 2;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES  = 250;
    localparam int unsigned HOLD_ITEMS   = 100;
    localparam int unsigned RAND_ITEMS   = 280;
    localparam int unsigned QUIET_FROM   = 200;
    localparam int unsigned PHASE_MAX    = 60;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    // Index one past the register list; the block must ignore it.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    // How a directed row's result is expected.
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_GIVEN} exp_kind_t;
    typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [PIXEL_W-1:0]     pix;
        exp_kind_t              exp_kind;
        psb_result_t            bin;
    } dir_row_t;

    localparam psb_result_t NO_BIN = '0;
    localparam int unsigned DIR_N  = 31;

    // Directed rows: small frames with sums that can be added up by hand.
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // First pixel after reset, 640 x 480 frame: bin not complete yet.
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd77,  EXP_NONE,  NO_BIN},
        '{ROW_CFG, REG_FRAME_WIDTH,  12'd2,    8'd0,   EXP_NONE,  NO_BIN},
        '{ROW_CFG, REG_FRAME_HEIGHT, 12'd2,    8'd0,   EXP_NONE,  NO_BIN},
        '{ROW_CFG, REG_BIN_SHIFT,    12'd1,    8'd0,   EXP_NONE,  NO_BIN},
        // One 2 x 2 bin of full-scale pixels.
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd255, EXP_MODEL, NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd255, EXP_MODEL, NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd255, EXP_MODEL, NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd255, EXP_GIVEN,
          '{16'd1020, 10'd0, 10'd0, 1'b1}},
        // Zero pixels: the first pixel of the bin overwrites the stored sum.
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd0,   EXP_MODEL, NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd0,   EXP_MODEL, NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd0,   EXP_MODEL, NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd0,   EXP_GIVEN,
          '{16'd0, 10'd0, 10'd0, 1'b1}},
        // Alternating bit patterns.
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'h55,  EXP_MODEL, NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'hAA,  EXP_MODEL, NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'hAA,  EXP_MODEL, NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'h55,  EXP_GIVEN,
          '{16'd510, 10'd0, 10'd0, 1'b1}},
        // Width zero acts as one: the frame is narrower than a bin, so no result.
        '{ROW_CFG, REG_FRAME_WIDTH,  12'd0,    8'd0,   EXP_NONE,  NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd255, EXP_NONE,  NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd255, EXP_NONE,  NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd255, EXP_NONE,  NO_BIN},
        // 4 x 2 frame with shift zero acting as one: two bins side by side.
        '{ROW_CFG, REG_FRAME_WIDTH,  12'd4,    8'd0,   EXP_NONE,  NO_BIN},
        '{ROW_CFG, REG_BIN_SHIFT,    12'd0,    8'd0,   EXP_NONE,  NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd1,   EXP_MODEL, NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd2,   EXP_MODEL, NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd3,   EXP_MODEL, NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd4,   EXP_MODEL, NO_BIN},
        // A write past the register list must not restart the frame.
        '{ROW_CFG, REG_UNUSED,       12'hFFF,  8'd0,   EXP_NONE,  NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd5,   EXP_MODEL, NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd6,   EXP_GIVEN,
          '{16'd14, 10'd0, 10'd0, 1'b0}},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd7,   EXP_MODEL, NO_BIN},
        '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd8,   EXP_GIVEN,
          '{16'd22, 10'd0, 10'd1, 1'b1}}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [PIXEL_W-1:0]     pixel;
    logic                   out_valid;
    logic                   out_stall;
    logic [SUM_W-1:0]       bin_sum;
    logic [BIN_IDX_W-1:0]   bin_row;
    logic [BIN_IDX_W-1:0]   bin_col;
    logic                   frame_last;

    // Predictor state: register copies, positions and per-bin-column partial sums.
    logic [CFG_DATA_W-1:0]  cfg_w;
    logic [CFG_DATA_W-1:0]  cfg_h;
    logic [SHIFT_W-1:0]     cfg_s;
    logic [10:0]            row_pos;
    logic [10:0]            col_pos;
    logic [ACC_W-1:0]       line_sums [STORE_DEPTH];

    psb_result_t            bins_due [$];
    psb_result_t            want_bin;

    bit                     quiet;
    bit                     hold_req;
    bit                     hold_taken;
    int unsigned            hold_cnt;
    int unsigned            cycle_cnt;
    int unsigned            mismatches = 0;
    int unsigned            bins_checked = 0;
    int unsigned            pixels_sent;
    int unsigned            cfg_writes;
    int unsigned            rand_items;

    pixel_sum_binning_top #(
        .MAX_WIDTH     (MAX_W),
        .MAX_HEIGHT    (MAX_H),
        .MAX_BIN_SHIFT (MAX_SHIFT)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_sum    (bin_sum),
        .bin_row    (bin_row),
        .bin_col    (bin_col),
        .frame_last (frame_last)
    );

    always #2 clk = ~clk;

    // Frame dimension as the block uses it: zero acts as one, large values saturate.
    function automatic int unsigned eff_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned lim);
        if (v == 0)
            return 1;
        if (32'(v) > lim)
            return lim;
        return 32'(v);
    endfunction

    // Predict one accepted pixel; returns 1 when it completes a bin.
    function automatic bit bin_step(input logic [PIXEL_W-1:0] p, output psb_result_t res);
        int unsigned      w;
        int unsigned      h;
        int unsigned      s;
        int unsigned      edge_m;
        int unsigned      bins_w;
        int unsigned      bins_h;
        int unsigned      bc;
        int unsigned      br;
        int unsigned      nc;
        int unsigned      nr;
        logic [ACC_W-1:0] acc;
        bit               made;
        w = eff_dim(cfg_w, MAX_W);
        h = eff_dim(cfg_h, MAX_H);
        s = (cfg_s == 0) ? 1 : ((32'(cfg_s) > MAX_SHIFT) ? MAX_SHIFT : 32'(cfg_s));
        edge_m = (1 << s) - 1;
        bins_w = w >> s;
        bins_h = h >> s;
        made = 1'b0;
        res = '0;
        if (bins_w != 0 && bins_h != 0 && 32'(col_pos) < (bins_w << s) &&
            32'(row_pos) < (bins_h << s))
        begin
            bc = 32'(col_pos) >> s;
            br = 32'(row_pos) >> s;
            if (bc < STORE_DEPTH)
            begin
                // The first pixel of a bin starts the sum; the rest add to it.
                if ((32'(col_pos) & edge_m) == 0 && (32'(row_pos) & edge_m) == 0)
                    acc = ACC_W'(p);
                else
                    acc = line_sums[bc] + ACC_W'(p);
                line_sums[bc] = acc;
                if ((32'(col_pos) & edge_m) == edge_m && (32'(row_pos) & edge_m) == edge_m)
                begin
                    res.sum  = acc[SUM_W-1:0];
                    res.row  = br[BIN_IDX_W-1:0];
                    res.col  = bc[BIN_IDX_W-1:0];
                    res.last = (br == bins_h - 1) && (bc == bins_w - 1);
                    made = 1'b1;
                end
            end
        end
        // Raster advance with wrap to the next frame.
        nc = 32'(col_pos) + 1;
        nr = 32'(row_pos);
        if (nc >= w)
        begin
            nc = 0;
            nr = 32'(row_pos) + 1;
            if (nr >= h)
                nr = 0;
        end
        col_pos = nc[10:0];
        row_pos = nr[10:0];
        return made;
    endfunction

    // Pixel values with the extremes well represented.
    function automatic logic [PIXEL_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return 12'd0;
            1:       return 12'd1;
            default: return CFG_DATA_W'($urandom_range(2, 12));
        endcase
    endfunction

    // Shift register data: random upper bits, mostly small shifts, some out of range.
    function automatic logic [CFG_DATA_W-1:0] pick_shift_data();
        logic [SHIFT_W-1:0] s;
        case ($urandom_range(0, 9))
            0:       s = 3'd0;
            1:       s = SHIFT_W'($urandom_range(3, 7));
            2, 3:    s = 3'd2;
            default: s = 3'd1;
        endcase
        return CFG_DATA_W'(($urandom_range(0, 511) << SHIFT_W) | 32'(s));
    endfunction

    // Offer one pixel request, hold it through stalls and record what it should produce.
    task automatic send_pixel(input logic [PIXEL_W-1:0] p, input exp_kind_t ek,
                              input psb_result_t given);
        psb_result_t calc;
        bit          made;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid = 1'b1;
        pixel = p;
        do
            @(posedge clk);
        while (in_stall);
        made = bin_step(p, calc);
        if (ek == EXP_GIVEN)
            bins_due.push_back(given);
        else if (ek == EXP_MODEL && made)
            bins_due.push_back(calc);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected bin has been seen.
    task automatic drain_bins();
        in_valid = 1'b0;
        while (bins_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Register write while the block is idle; mirrors the register and the restart.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_bins();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        case (idx)
            REG_FRAME_WIDTH:  cfg_w = data;
            REG_FRAME_HEIGHT: cfg_h = data;
            REG_BIN_SHIFT:    cfg_s = data[SHIFT_W-1:0];
            default:          ;
        endcase
        if (idx != REG_UNUSED)
        begin
            row_pos = '0;
            col_pos = '0;
        end
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_writes++;
    endtask

    // One random phase: maybe new registers, then whole frames and sometimes a partial one.
    task automatic random_phase();
        int unsigned fsize;
        int unsigned n;
        if ($urandom_range(0, 1))
            write_reg(REG_FRAME_WIDTH, pick_dim());
        if ($urandom_range(0, 1))
            write_reg(REG_FRAME_HEIGHT, pick_dim());
        if ($urandom_range(0, 1))
            write_reg(REG_BIN_SHIFT, pick_shift_data());
        if ($urandom_range(0, 5) == 0)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 4095)));
        fsize = eff_dim(cfg_w, MAX_W) * eff_dim(cfg_h, MAX_H);
        n = fsize * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0)
            n = n + $urandom_range(0, fsize);
        if (n > PHASE_MAX)
            n = PHASE_MAX;
        repeat (n)
        begin
            send_pixel(rand_pixel(), EXP_MODEL, NO_BIN);
            rand_items++;
        end
    endtask

    task automatic check_field(input string name, input logic [SUM_W-1:0] exp_v,
                               input logic [SUM_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Compare every accepted result with the oldest expected bin.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (bins_due.size() == 0)
            begin
                $error("unexpected bin: sum %0d row %0d col %0d last %0d",
                       bin_sum, bin_row, bin_col, frame_last);
                mismatches++;
            end
            else
            begin
                want_bin = bins_due.pop_front();
                bins_checked++;
                check_field("bin_sum", want_bin.sum, bin_sum);
                check_field("bin_row", want_bin.row, bin_row);
                check_field("bin_col", want_bin.col, bin_col);
                check_field("frame_last", want_bin.last, frame_last);
            end
        end
    end

    // Output back-pressure: random stall bursts plus one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        hold_taken = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_stall = 1'b1;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(negedge clk);
                out_stall = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Watchdog on total run length.
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("simulation failed");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        pixels_sent = 0;
        cfg_writes = 0;
        rand_items = 0;
        cfg_w = FRAME_WIDTH_RST;
        cfg_h = FRAME_HEIGHT_RST;
        cfg_s = BIN_SHIFT_RST;
        row_pos = '0;
        col_pos = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed rows.
        for (int i = 0; i < DIR_N; i++)
        begin
            if (DIR_ROWS[i].kind == ROW_CFG)
                write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
            else
                send_pixel(DIR_ROWS[i].pix, DIR_ROWS[i].exp_kind, DIR_ROWS[i].bin);
        end

        // Largest bin with bright pixels: the sum wraps past 16 bits.
        write_reg(REG_FRAME_WIDTH, 12'd32);
        write_reg(REG_FRAME_HEIGHT, 12'd32);
        write_reg(REG_BIN_SHIFT, 12'd7);
        repeat (1024) send_pixel(PIXEL_W'($urandom_range(192, 255)), EXP_MODEL, NO_BIN);

        // Long output hold-off while pixels keep coming, so the input backs up.
        write_reg(REG_FRAME_WIDTH, 12'd4);
        write_reg(REG_FRAME_HEIGHT, 12'd4);
        write_reg(REG_BIN_SHIFT, 12'd1);
        hold_req = 1'b1;
        repeat (HOLD_ITEMS) send_pixel(rand_pixel(), EXP_MODEL, NO_BIN);

        // Random phases on small frames; the tail runs without idling.
        write_reg(REG_FRAME_WIDTH, pick_dim());
        write_reg(REG_FRAME_HEIGHT, pick_dim());
        while (rand_items < RAND_ITEMS)
        begin
            quiet = (rand_items >= QUIET_FROM);
            random_phase();
        end

        drain_bins();
        repeat (10) @(negedge clk);
        if (bins_due.size() != 0)
            $error("%0d expected bins never arrived", bins_due.size());
        $display("Accepted %0d pixel requests across %0d register writes; checked %0d bins.",
                 pixels_sent, cfg_writes, bins_checked);
        $display("Frames 1 to 32 pixels per side, bin edges 2 to 32, %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && bins_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
src/psb_pkg.sv
src/psb_out_queue.sv
src/pixel_sum_binning_top.sv
sim/tb_pixel_sum_binning_top.sv
